>>> hdl/rc4_pkg.sv
package rc4_pkg;

    // Key storage: four 64-bit words, byte n at bits 8*(n%8) of word n/8
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int MAX_KEY_BYTES = 32;
    localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LEN_W     = 6;
    localparam int CFG_IDX_W     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

    localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 6'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_message;
    } data_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       result_last;
    } result_t;

    // Microcode addresses
    typedef logic [3:0] step_t;

    localparam step_t ST_IDLE = 4'd0;
    localparam step_t ST_INIT = 4'd1;
    localparam step_t ST_K0   = 4'd2;
    localparam step_t ST_K1   = 4'd3;
    localparam step_t ST_K2   = 4'd4;
    localparam step_t ST_K3   = 4'd5;
    localparam step_t ST_KEND = 4'd6;
    localparam step_t ST_G1   = 4'd7;
    localparam step_t ST_G2   = 4'd8;
    localparam step_t ST_G3   = 4'd9;
    localparam step_t ST_G4   = 4'd10;
    localparam step_t ST_G5   = 4'd11;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_ACCEPT,
        SEQ_EMIT
    } seq_op_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_N,
        RD_N_INC,
        RD_JSUM,
        RD_T
    } rd_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_N_IDX,
        WR_N_Q,
        WR_J_SI
    } wr_op_t;

    typedef enum logic [1:0] {
        J_HOLD,
        J_SUM,
        J_SUM_KEY,
        J_CLR
    } j_op_t;

    typedef struct packed {
        seq_op_t seq;
        step_t   target;
        rd_op_t  rd;
        wr_op_t  wr;
        j_op_t   j_op;
        logic    n_inc;
        logic    kidx_step;
        logic    si_ld;
        logic    sj_ld;
        logic    byp_ld;
        logic    need_clr;
    } ctl_t;

    // Control store
    function automatic ctl_t ucode(input step_t s);
        ctl_t c;
        c        = '0;
        c.seq    = SEQ_NEXT;
        c.target = ST_IDLE;
        c.rd     = RD_NONE;
        c.wr     = WR_NONE;
        c.j_op   = J_HOLD;
        unique case (s)
            ST_IDLE:
            begin
                c.seq = SEQ_ACCEPT;
            end
            ST_INIT:
            begin
                c.seq    = SEQ_LOOP;
                c.target = ST_INIT;
                c.wr     = WR_N_IDX;
                c.n_inc  = 1'b1;
            end
            ST_K0:
            begin
                c.rd = RD_N;
            end
            ST_K1:
            begin
                c.rd    = RD_JSUM;
                c.j_op  = J_SUM_KEY;
                c.si_ld = 1'b1;
            end
            ST_K2:
            begin
                c.wr = WR_N_Q;
            end
            ST_K3:
            begin
                c.seq       = SEQ_LOOP;
                c.target    = ST_K0;
                c.wr        = WR_J_SI;
                c.n_inc     = 1'b1;
                c.kidx_step = 1'b1;
            end
            ST_KEND:
            begin
                c.j_op     = J_CLR;
                c.need_clr = 1'b1;
            end
            ST_G1:
            begin
                c.rd    = RD_N_INC;
                c.n_inc = 1'b1;
            end
            ST_G2:
            begin
                c.rd    = RD_JSUM;
                c.j_op  = J_SUM;
                c.si_ld = 1'b1;
            end
            ST_G3:
            begin
                c.wr    = WR_N_Q;
                c.sj_ld = 1'b1;
            end
            ST_G4:
            begin
                c.wr     = WR_J_SI;
                c.rd     = RD_T;
                c.byp_ld = 1'b1;
            end
            ST_G5:
            begin
                c.seq = SEQ_EMIT;
            end
            default:
            begin
                c.seq = SEQ_ACCEPT;
            end
        endcase
        return c;
    endfunction

endpackage

>>> hdl/rc4_stream_cipher.sv
// RC4 stream cipher, one byte per beat: each data byte is XORed with the next keystream
// byte, so the same block encrypts and decrypts. No new byte is taken until the result of
// the previous byte has been emitted; the microcode walks the dependent S[i], S[j], S[t]
// reads and the swap through one 256 x 8 permutation memory with one read port, one write
// port and registered read. A result that is not taken holds the sequencer at its last
// step until the output register frees. The first byte after reset, and the first after a
// byte marked last, also runs the key schedule over the configured key first: it loads
// the identity permutation, then runs one key schedule step per permutation entry.
// Key registers may be written at any time and are used at the next key schedule; key
// length 0 acts as 1 and lengths above 32 saturate to 32.
module rc4_stream_cipher
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rc4_pkg::KEY_WORD_W-1:0]    cfg_data,
    input  logic                              data_valid,
    output logic                              data_ready,
    input  rc4_pkg::data_t                    data,
    output logic                              result_valid,
    input  logic                              result_ready,
    output rc4_pkg::result_t                  result
);

    localparam int KEY_BITS = rc4_pkg::KEY_WORDS * rc4_pkg::KEY_WORD_W;

    // Control state
    rc4_pkg::step_t                    step_reg, step_next;
    logic [7:0]                        n_reg, n_next;
    logic [7:0]                        j_reg, j_next;
    logic [rc4_pkg::KIDX_W-1:0]        kidx_reg, kidx_next;
    logic                              need_reg, need_next;
    logic                              out_valid_reg, out_valid_next;

    logic [rc4_pkg::KEY_WORD_W-1:0]    key_reg [rc4_pkg::KEY_WORDS];
    logic [rc4_pkg::KEY_LEN_W-1:0]     key_len_reg;

    // Datapath
    rc4_pkg::data_t                    din_reg;
    rc4_pkg::result_t                  out_reg;
    logic [7:0]                        si_reg;
    logic [7:0]                        sj_reg;
    logic                              byp_reg;
    logic [7:0]                        mem_q_reg;
    logic [7:0]                        perm_mem [256];

    rc4_pkg::ctl_t                     ctl;
    logic                              accept;
    logic                              out_free;
    logic                              emit;
    logic [KEY_BITS-1:0]               key_bits;
    logic [7:0]                        key_byte;
    logic [rc4_pkg::KEY_LEN_W-1:0]     eff_len;
    logic [rc4_pkg::KEY_LEN_W-1:0]     len_m1;
    logic [7:0]                        jsum;
    logic [7:0]                        t_addr;
    logic [7:0]                        keystream;
    logic                              rd_en;
    logic [7:0]                        rd_addr;
    logic                              wr_en;
    logic [7:0]                        wr_addr;
    logic [7:0]                        wr_data;

    assign ctl        = rc4_pkg::ucode(step_reg);
    assign data_ready = (ctl.seq == rc4_pkg::SEQ_ACCEPT);
    assign accept     = data_ready && data_valid;
    assign out_free   = !out_valid_reg || result_ready;
    assign emit       = (ctl.seq == rc4_pkg::SEQ_EMIT) && out_free;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Key byte selection
    assign key_bits = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
    assign key_byte = key_bits[{kidx_reg, 3'b000} +: 8];

    always_comb
    begin
        if (key_len_reg == '0)
        begin
            eff_len = rc4_pkg::KEY_LEN_W'(1);
        end
        else if (key_len_reg > rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES))
        begin
            eff_len = rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES);
        end
        else
        begin
            eff_len = key_len_reg;
        end
    end

    assign len_m1 = eff_len - rc4_pkg::KEY_LEN_W'(1);

    assign jsum      = j_reg + mem_q_reg +
                       ((ctl.j_op == rc4_pkg::J_SUM_KEY) ? key_byte : 8'd0);
    assign t_addr    = si_reg + sj_reg;
    assign keystream = byp_reg ? si_reg : mem_q_reg;

    // Memory port selection
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = n_reg;
        unique case (ctl.rd)
            rc4_pkg::RD_NONE:  rd_en   = 1'b0;
            rc4_pkg::RD_N:     rd_addr = n_reg;
            rc4_pkg::RD_N_INC: rd_addr = n_reg + 8'd1;
            rc4_pkg::RD_JSUM:  rd_addr = jsum;
            rc4_pkg::RD_T:     rd_addr = t_addr;
            default:           rd_en   = 1'b0;
        endcase

        wr_en   = 1'b1;
        wr_addr = n_reg;
        wr_data = mem_q_reg;
        unique case (ctl.wr)
            rc4_pkg::WR_NONE:  wr_en   = 1'b0;
            rc4_pkg::WR_N_IDX: wr_data = n_reg;
            rc4_pkg::WR_N_Q:   wr_data = mem_q_reg;
            rc4_pkg::WR_J_SI:
            begin
                wr_addr = j_reg;
                wr_data = si_reg;
            end
            default:           wr_en   = 1'b0;
        endcase
    end

    // Sequencer and control state next values
    always_comb
    begin
        step_next      = step_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        kidx_next      = kidx_reg;
        need_next      = need_reg;
        out_valid_next = out_valid_reg;

        unique case (ctl.seq)
            rc4_pkg::SEQ_NEXT:
            begin
                step_next = step_reg + rc4_pkg::step_t'(1);
            end
            rc4_pkg::SEQ_LOOP:
            begin
                step_next = (n_reg == 8'hFF) ? step_reg + rc4_pkg::step_t'(1) : ctl.target;
            end
            rc4_pkg::SEQ_ACCEPT:
            begin
                if (accept)
                begin
                    step_next = need_reg ? rc4_pkg::ST_INIT : rc4_pkg::ST_G1;
                    if (need_reg)
                    begin
                        n_next    = 8'd0;
                        j_next    = 8'd0;
                        kidx_next = '0;
                    end
                end
            end
            rc4_pkg::SEQ_EMIT:
            begin
                if (emit)
                begin
                    step_next = rc4_pkg::ST_IDLE;
                end
            end
            default:
            begin
                step_next = rc4_pkg::ST_IDLE;
            end
        endcase

        if (ctl.n_inc)
        begin
            n_next = n_reg + 8'd1;
        end

        if (ctl.kidx_step)
        begin
            kidx_next = (rc4_pkg::KEY_LEN_W'(kidx_reg) == len_m1) ? '0 :
                        kidx_reg + rc4_pkg::KIDX_W'(1);
        end

        case (ctl.j_op) inside
            rc4_pkg::J_SUM, rc4_pkg::J_SUM_KEY: j_next = jsum;
            rc4_pkg::J_CLR:                     j_next = 8'd0;
            default:                            ;
        endcase

        if (ctl.need_clr)
        begin
            need_next = 1'b0;
        end

        if (emit)
        begin
            need_next      = din_reg.last_of_message;
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= rc4_pkg::ST_IDLE;
            n_reg         <= 8'd0;
            j_reg         <= 8'd0;
            kidx_reg      <= '0;
            need_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            key_reg[0]    <= '0;
            key_reg[1]    <= '0;
            key_reg[2]    <= '0;
            key_reg[3]    <= '0;
            key_len_reg   <= rc4_pkg::KEY_LENGTH_RESET;
        end
        else
        begin
            step_reg      <= step_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            kidx_reg      <= kidx_next;
            need_reg      <= need_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index) inside
                    rc4_pkg::CFG_KEY_WORD_0, rc4_pkg::CFG_KEY_WORD_1,
                    rc4_pkg::CFG_KEY_WORD_2, rc4_pkg::CFG_KEY_WORD_3:
                        key_reg[cfg_index[1:0]] <= cfg_data;
                    rc4_pkg::CFG_KEY_LENGTH:
                        key_len_reg <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // Payload registers and permutation memory
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            din_reg <= data;
        end
        if (ctl.si_ld)
        begin
            si_reg <= mem_q_reg;
        end
        if (ctl.sj_ld)
        begin
            sj_reg <= mem_q_reg;
        end
        if (ctl.byp_ld)
        begin
            // S[j] is written in the same cycle as the S[t] read
            byp_reg <= (t_addr == j_reg);
        end
        if (emit)
        begin
            out_reg.result_byte <= din_reg.data_byte ^ keystream;
            out_reg.result_last <= din_reg.last_of_message;
        end
        if (wr_en)
        begin
            perm_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= perm_mem[rd_addr];
        end
    end

endmodule

>>> hdl/rc4_chk.sv
module rc4_chk
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                data_valid,
    input  logic                data_ready,
    input  rc4_pkg::data_t      data,
    input  logic                result_valid,
    input  logic                result_ready,
    input  rc4_pkg::result_t    result
);

    // a result beat waiting for ready holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // no new byte is taken while the previous byte is in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && data_ready |=> !data_ready ##1 !data_ready ##1 !data_ready
            ##1 !data_ready ##1 !data_ready)
        else $error("data beat taken while previous byte in flight");

    // a fresh result leaves the block ready for the next byte
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> data_ready)
        else $error("result produced without returning to idle");

    // no result is produced while the block is waiting for input
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        data_ready && !(result_valid && !result_ready) |=> !$rose(result_valid))
        else $error("result beat appeared from idle");

endmodule

bind rc4_stream_cipher rc4_chk u_rc4_chk (.*);
